// File: hdl/assert_macros.svh
// Assertion macros used by max_alternating_square.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define MAS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/mas_pkg.sv
package mas_pkg;

  localparam int unsigned MaxCols = 2048;
  localparam int unsigned MaxRows = 2048;

  localparam int unsigned ColW   = $clog2(MaxCols);
  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned CntW   = 12;
  localparam int unsigned SideW  = 12;
  localparam int unsigned AreaW  = 23;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = ((AreaW + SideW + 7) / 8) * 8;

  localparam logic [SideW-1:0] SideMax = {SideW{1'b1}};
  localparam logic [CntW-1:0]  ColMax  = CntW'(MaxCols);
  localparam logic [CntW-1:0]  RowMax  = CntW'(MaxRows);

  typedef enum logic [0:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  // One column entry of the line store.
  typedef struct packed {
    logic             value;
    logic [SideW-1:0] vrun;
    logic [SideW-1:0] side;
  } line_t;

  // Position of a cell within the grid.
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  // Running state of the current row.
  typedef struct packed {
    logic             left_value;
    logic             left_vgt;
    logic [SideW-1:0] hrun;
    logic [SideW-1:0] diag;
  } row_state_t;

  function automatic logic [SideW-1:0] inc_sat(input logic [SideW-1:0] v);
    inc_sat = (v == SideMax) ? SideMax : v + SideW'(1);
  endfunction

  function automatic logic [CntW-1:0] clamp_count(input logic [CntW-1:0] v,
                                                  input logic [CntW-1:0] maxv);
    if (v == '0) begin
      clamp_count = CntW'(1);
    end else if (v > maxv) begin
      clamp_count = maxv;
    end else begin
      clamp_count = v;
    end
  endfunction

endpackage

// File: hdl/mas_cell_core.sv
module mas_cell_core (
  input  logic                        cell_i,
  input  mas_pkg::pos_flags_t         flags_i,
  input  mas_pkg::line_t              above_i,
  input  mas_pkg::row_state_t         row_i,
  output mas_pkg::line_t              line_o,
  output logic [mas_pkg::SideW-1:0]   hrun_o
);

  logic [mas_pkg::SideW-1:0] h;
  logic [mas_pkg::SideW-1:0] vr;
  logic [mas_pkg::SideW-1:0] dg;
  logic [mas_pkg::SideW-1:0] m;
  logic [mas_pkg::SideW-1:0] side;

  always_comb begin
    if (flags_i.first_col || (cell_i == row_i.left_value)) begin
      h = mas_pkg::SideW'(1);
    end else begin
      h = mas_pkg::inc_sat(row_i.hrun);
    end

    if (flags_i.first_row || (cell_i == above_i.value)) begin
      vr = mas_pkg::SideW'(1);
    end else begin
      vr = mas_pkg::inc_sat(above_i.vrun);
    end

    dg = mas_pkg::inc_sat(row_i.diag);
    m  = (dg < h) ? dg : h;
    m  = (m < vr) ? m : vr;

    // The upper-left cell matches this one exactly when the left cell
    // differs from the cell above it.
    if (flags_i.first_row || flags_i.first_col) begin
      side = mas_pkg::SideW'(1);
    end else if ((cell_i != row_i.left_value) && (cell_i != above_i.value) &&
                 row_i.left_vgt) begin
      side = m;
    end else begin
      side = mas_pkg::SideW'(1);
    end
  end

  assign line_o.value = cell_i;
  assign line_o.vrun  = vr;
  assign line_o.side  = side;
  assign hrun_o       = h;

endmodule

// File: hdl/max_alternating_square.sv
// The last cell of a grid passes the input register, then its result is held in the result register.
// Throughput: one cell per cycle but for the stall below; the line store has one read and one write
// port, and a read that hits the column being written is forwarded.
// A waiting result stalls the input only while the last cell of the next grid
// sits in the input register; all other cells keep entering.
// Reset clears positions, run state and the best side (to 1); counts reset to 1.
module max_alternating_square (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_addr_i,
  input  logic [mas_pkg::CntW-1:0]        cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] cell_value, [7:1] zero
  input  logic [mas_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [22:0] max_area, [34:23] max_side, [39:35] zero
  output logic [mas_pkg::OutDataW-1:0]    m_axis_tdata
);

  `include "assert_macros.svh"

  logic [mas_pkg::CntW-1:0] row_count_q, col_count_q;
  logic [mas_pkg::CntW-1:0] rows, cols;

  logic [mas_pkg::ColW-1:0] pos_c_q, pos_c_d;
  logic [mas_pkg::RowW-1:0] pos_r_q, pos_r_d;
  mas_pkg::pos_flags_t      in_flags;
  logic                     in_acc;

  logic                     s1_valid_q;
  logic                     s1_cell_q;
  logic [mas_pkg::ColW-1:0] s1_col_q;
  mas_pkg::pos_flags_t      s1_flags_q;
  logic                     s1_adv;
  logic                     s1_done;

  mas_pkg::line_t           mem [mas_pkg::MaxCols];
  mas_pkg::line_t           rd_raw_q;
  mas_pkg::line_t           byp_data_q;
  logic                     byp_q;
  mas_pkg::line_t           above;
  mas_pkg::line_t           wr_line;

  mas_pkg::row_state_t      row_q, row_d;
  logic [mas_pkg::SideW-1:0] hrun_new;
  logic [mas_pkg::SideW-1:0] best_q, best_d, best_new;

  logic                     out_valid_q;
  logic [mas_pkg::SideW-1:0] out_side_q;
  logic [2*mas_pkg::SideW-1:0] out_sq;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= mas_pkg::CntW'(1);
      col_count_q <= mas_pkg::CntW'(1);
    end else if (cfg_we_i) begin
      case (mas_pkg::cfg_reg_e'(cfg_addr_i))
        mas_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i;
        mas_pkg::REG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows = mas_pkg::clamp_count(row_count_q, mas_pkg::RowMax);
  assign cols = mas_pkg::clamp_count(col_count_q, mas_pkg::ColMax);

  // Front end: position tracking and line store read
  assign s1_done       = s1_flags_q.last_col && s1_flags_q.last_row;
  assign s1_adv        = s1_valid_q && (!s1_done || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_flags.first_row = (pos_r_q == '0);
    in_flags.first_col = (pos_c_q == '0);
    in_flags.last_col  = ((mas_pkg::CntW'(pos_c_q) + mas_pkg::CntW'(1)) >= cols);
    in_flags.last_row  = ((mas_pkg::CntW'(pos_r_q) + mas_pkg::CntW'(1)) >= rows);
    pos_c_d = pos_c_q + mas_pkg::ColW'(1);
    pos_r_d = pos_r_q;
    if (in_flags.last_col) begin
      pos_c_d = '0;
      pos_r_d = in_flags.last_row ? '0 : pos_r_q + mas_pkg::RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_c_q    <= '0;
      pos_r_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_c_q <= pos_c_d;
        pos_r_q <= pos_r_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cell_q  <= s_axis_tdata[0];
      s1_col_q   <= pos_c_q;
      s1_flags_q <= in_flags;
      rd_raw_q   <= mem[pos_c_q];
      byp_q      <= s1_adv && (s1_col_q == pos_c_q);
      byp_data_q <= wr_line;
    end
    if (s1_adv) begin
      mem[s1_col_q] <= wr_line;
    end
  end

  assign above = byp_q ? byp_data_q : rd_raw_q;

  // Cell update
  mas_cell_core u_core (
    .cell_i  (s1_cell_q),
    .flags_i (s1_flags_q),
    .above_i (above),
    .row_i   (row_q),
    .line_o  (wr_line),
    .hrun_o  (hrun_new)
  );

  assign best_new = (wr_line.side > best_q) ? wr_line.side : best_q;

  always_comb begin
    row_d.left_value = s1_cell_q;
    row_d.left_vgt   = (wr_line.vrun > mas_pkg::SideW'(1));
    row_d.hrun       = hrun_new;
    row_d.diag       = above.side;
    best_d           = best_new;
    if (s1_flags_q.last_col) begin
      row_d = '0;
      if (s1_flags_q.last_row) begin
        best_d = mas_pkg::SideW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      best_q <= mas_pkg::SideW'(1);
    end else if (s1_adv) begin
      row_q  <= row_d;
      best_q <= best_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_done) begin
      out_side_q <= best_new;
    end
  end

  assign out_sq        = out_side_q * out_side_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(mas_pkg::OutDataW - mas_pkg::AreaW - mas_pkg::SideW){1'b0}},
                          out_side_q, out_sq[mas_pkg::AreaW-1:0]};

  `MAS_NEVER(a_out_side_nonzero, out_valid_q && (out_side_q == '0), "result side is zero")
  `MAS_NEVER(a_best_nonzero, best_q == '0, "best side is zero")
  `MAS_ASSERT(a_stall_cause, (s1_valid_q && !s1_adv) |-> (out_valid_q && !m_axis_tready), "stage stalled without a held result")
  `MAS_ASSERT(a_result_issued, (s1_adv && s1_done) |=> out_valid_q, "last cell produced no result")

endmodule

// File: tb/sv/tb_max_alternating_square.sv
`timescale 1ns / 100ps

module tb_max_alternating_square;

  localparam int RandomCells   = 1700;
  localparam int StallLimit    = 2000;
  localparam int MaxMismatches = 10;

  typedef struct packed {
    logic [mas_pkg::AreaW-1:0] area;
    logic [mas_pkg::SideW-1:0] side;
  } square_result_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [0:0]                   cfg_addr_i    = mas_pkg::REG_ROW_COUNT;
  logic [mas_pkg::CntW-1:0]     cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [mas_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [mas_pkg::OutDataW-1:0] m_axis_tdata;

  bit             cell_queue[$];
  square_result_t expected_squares[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          stall_cycles   = 0;

  // Grid tracker state.
  logic [mas_pkg::CntW-1:0]  row_count_reg = mas_pkg::CntW'(1);
  logic [mas_pkg::CntW-1:0]  col_count_reg = mas_pkg::CntW'(1);
  bit                        above_value[mas_pkg::MaxCols];
  logic [mas_pkg::SideW-1:0] above_vrun[mas_pkg::MaxCols];
  logic [mas_pkg::SideW-1:0] above_side[mas_pkg::MaxCols];
  bit               left_cell     = 1'b0;
  int               row_run       = 0;
  int               corner_side   = 0;
  int               largest_side  = 1;
  int               col_pos       = 0;
  int               row_pos       = 0;

  max_alternating_square u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int run_inc(input int v);
    return (v >= int'(mas_pkg::SideMax)) ? int'(mas_pkg::SideMax) : v + 1;
  endfunction

  function automatic int effective_count(input logic [mas_pkg::CntW-1:0] v,
                                         input int limit);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  task automatic absorb_cell(input bit v);
    int rows;
    int cols;
    int c;
    int h;
    int vr;
    int side;
    int old_side;
    bit first_row;
    bit first_col;
    square_result_t res;
    rows = effective_count(row_count_reg, mas_pkg::MaxRows);
    cols = effective_count(col_count_reg, mas_pkg::MaxCols);
    c = (col_pos >= mas_pkg::MaxCols) ? mas_pkg::MaxCols - 1 : col_pos;
    first_row = (row_pos == 0);
    first_col = (c == 0);
    h  = (first_col || v == left_cell) ? 1 : run_inc(row_run);
    vr = (first_row || v == above_value[c]) ? 1 : run_inc(int'(above_vrun[c]));
    old_side = int'(above_side[c]);
    side = 1;
    if (!first_row && !first_col && v != left_cell && v != above_value[c]) begin
      if (above_vrun[c-1] > 1) begin
        side = run_inc(corner_side);
        if (h < side) side = h;
        if (vr < side) side = vr;
      end
    end
    above_value[c] = v;
    above_vrun[c]  = mas_pkg::SideW'(vr);
    above_side[c]  = mas_pkg::SideW'(side);
    corner_side    = old_side;
    left_cell      = v;
    row_run        = h;
    if (side > largest_side) largest_side = side;
    if (c + 1 < cols) begin
      col_pos = c + 1;
    end else if (row_pos + 1 < rows) begin
      col_pos     = 0;
      row_pos     = row_pos + 1;
      left_cell   = 1'b0;
      row_run     = 0;
      corner_side = 0;
    end else begin
      res.area = mas_pkg::AreaW'(largest_side * largest_side);
      res.side = mas_pkg::SideW'(largest_side);
      expected_squares.push_back(res);
      col_pos      = 0;
      row_pos      = 0;
      left_cell    = 1'b0;
      row_run      = 0;
      corner_side  = 0;
      largest_side = 1;
    end
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_cell(s_axis_tdata[0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cell_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= mas_pkg::InDataW'(cell_queue.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    square_result_t want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_squares.size() == 0) begin
          if (mismatch_count < MaxMismatches) begin
            $display("Unexpected result: area %0d side %0d",
                     m_axis_tdata[mas_pkg::AreaW-1:0],
                     m_axis_tdata[mas_pkg::AreaW+mas_pkg::SideW-1:mas_pkg::AreaW]);
          end
          mismatch_count++;
        end else begin
          want = expected_squares.pop_front();
          if (m_axis_tdata[mas_pkg::AreaW-1:0] !== want.area ||
              m_axis_tdata[mas_pkg::AreaW+mas_pkg::SideW-1:mas_pkg::AreaW] !== want.side)
          begin
            if (mismatch_count < MaxMismatches) begin
              $display("Mismatch: expected area %0d side %0d, got area %0d side %0d",
                       want.area, want.side, m_axis_tdata[mas_pkg::AreaW-1:0],
                       m_axis_tdata[mas_pkg::AreaW+mas_pkg::SideW-1:mas_pkg::AreaW]);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with work outstanding and no handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cell_queue.size() == 0 && !s_axis_tvalid && expected_squares.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic wait_quiet();
    @(negedge clk_i);
    while (cell_queue.size() != 0 || s_axis_tvalid || expected_squares.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_count(input mas_pkg::cfg_reg_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= mas_pkg::CntW'(value);
    if (idx == mas_pkg::REG_ROW_COUNT) begin
      row_count_reg = mas_pkg::CntW'(value);
    end else begin
      col_count_reg = mas_pkg::CntW'(value);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_grid(input int rows, input int cols, input int unsigned flip_pct);
    bit phase;
    phase = 1'($urandom_range(1));
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        cell_queue.push_back(1'((r + c + phase) & 1) ^ ($urandom_range(99) < flip_pct));
      end
    end
  endtask

  task automatic queue_random_cells(input int n);
    repeat (n) cell_queue.push_back(1'($urandom_range(1)));
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        send_idle_pct  = 25;
        recv_stall_pct = 72;
      end
      1: begin
        send_idle_pct  = 72;
        recv_stall_pct = 25;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    int rows;
    int cols;
    int random_cells;
    int unsigned flip_pct;
    random_cells = 0;
    set_idling(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Counts at their reset value give a one-cell grid.
    cell_queue.push_back(1'b1);
    wait_quiet();

    // A count of zero acts as one.
    write_count(mas_pkg::REG_ROW_COUNT, 0);
    write_count(mas_pkg::REG_COL_COUNT, 0);
    cell_queue.push_back(1'b0);
    wait_quiet();

    write_count(mas_pkg::REG_ROW_COUNT, 3);
    write_count(mas_pkg::REG_COL_COUNT, 3);
    queue_grid(3, 3, 0);
    wait_quiet();

    // Column count lowered below the current position in the middle of a row.
    write_count(mas_pkg::REG_ROW_COUNT, 3);
    write_count(mas_pkg::REG_COL_COUNT, 4);
    queue_random_cells(7);
    wait_quiet();
    write_count(mas_pkg::REG_COL_COUNT, 2);
    queue_random_cells(3);
    wait_quiet();

    // Row count lowered below the current row in the middle of a grid.
    write_count(mas_pkg::REG_ROW_COUNT, 3);
    write_count(mas_pkg::REG_COL_COUNT, 2);
    queue_random_cells(5);
    wait_quiet();
    write_count(mas_pkg::REG_ROW_COUNT, 2);
    queue_random_cells(1);
    wait_quiet();

    while (random_cells < RandomCells) begin
      set_idling(random_cells * 3 / RandomCells);
      case ($urandom_range(9))
        0: begin
          rows = $urandom_range(1, 4);
          cols = $urandom_range(1, 60);
        end
        1: begin
          rows = $urandom_range(1, 60);
          cols = $urandom_range(1, 4);
        end
        default: begin
          rows = $urandom_range(1, 10);
          cols = $urandom_range(1, 10);
        end
      endcase
      case ($urandom_range(4))
        0: flip_pct = 0;
        1: flip_pct = 2;
        2: flip_pct = 5;
        3: flip_pct = 15;
        default: flip_pct = 50;
      endcase
      write_count(mas_pkg::REG_ROW_COUNT, (rows == 1 && $urandom_range(1)) ? 0 : rows);
      write_count(mas_pkg::REG_COL_COUNT, (cols == 1 && $urandom_range(1)) ? 0 : cols);
      queue_grid(rows, cols, flip_pct);
      random_cells += rows * cols;
      wait_quiet();
    end

    repeat (10) @(posedge clk_i);
    mismatch_count += expected_squares.size();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mas_pkg.sv
hdl/mas_cell_core.sv
hdl/max_alternating_square.sv
tb/sv/tb_max_alternating_square.sv
